@@ design/sm3_pkg.sv @@
`default_nettype none
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [255:0] IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    typedef struct packed {
        logic start;
        logic busy;
    } round_ctl_t;

    function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
    endfunction
endpackage
`default_nettype wire

@@ design/sm3_round.sv @@
`default_nettype none
module sm3_round (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [511:0]       block,
    input  wire logic               cv_init,
    output logic                    busy,
    output logic [255:0]            cv
);
    logic [255:0] cv_reg, cv_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [5:0]   rnd_reg;
    logic         busy_reg, last_reg;

    logic [31:0] wj, wj4, wnew, t, a12, ss1, ss2, ff, gg, tt1, tt2, x;
    logic        lowr;

    assign busy = busy_reg;
    assign cv   = cv_reg;

    always_comb begin
        lowr = (rnd_reg < 6'd16);
        x    = w_reg[0] ^ w_reg[7] ^ sm3_pkg::rol(w_reg[13], 5'd15);
        wnew = sm3_pkg::p1(x) ^ sm3_pkg::rol(w_reg[3], 5'd7) ^ w_reg[10];
        wj   = w_reg[0];
        wj4  = w_reg[4];
        t    = sm3_pkg::rol(lowr ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, rnd_reg[4:0]);
        a12  = sm3_pkg::rol(a_reg, 5'd12);
        ss1  = sm3_pkg::rol(a12 + e_reg + t, 5'd7);
        ss2  = ss1 ^ a12;
        ff   = lowr ? (a_reg ^ b_reg ^ c_reg)
                    : ((a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg));
        gg   = lowr ? (e_reg ^ f_reg ^ g_reg) : ((e_reg & f_reg) | (~e_reg & g_reg));
        tt1  = ff + d_reg + ss2 + (wj ^ wj4);
        tt2  = gg + h_reg + ss1 + wj;
        cv_next = cv_reg ^ {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            rnd_reg  <= '0;
            cv_reg   <= sm3_pkg::IV;
        end else if (cv_init) begin
            cv_reg <= sm3_pkg::IV;
        end else if (start) begin
            busy_reg <= 1'b1;
            rnd_reg  <= '0;
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= cv_reg;
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= block[511 - 32*i -: 32];
            end
        end else if (last_reg) begin
            last_reg <= 1'b0;
            cv_reg   <= cv_next;
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            d_reg <= c_reg;
            c_reg <= sm3_pkg::rol(b_reg, 5'd9);
            b_reg <= a_reg;
            a_reg <= tt1;
            h_reg <= g_reg;
            g_reg <= sm3_pkg::rol(f_reg, 5'd19);
            f_reg <= e_reg;
            e_reg <= sm3_pkg::p0(tt2);
            rnd_reg <= rnd_reg + 6'd1;
            if (rnd_reg == 6'd63) begin
                busy_reg <= 1'b0;
                last_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/sm3_hash_engine.sv @@
// SM3 hash engine, byte-serial.
// s_axis: tdata[7:0] message byte, tuser action (0 absorb, 1 finish).
// m_axis: tdata[31:0] digest word, tdata[34:32] word index, tlast on word 7.
// An absorb item is taken while the engine is idle; each 64th byte starts a
// block compression (one SM3 round per cycle in a shared round unit) during
// which s_axis_tready is low.
// A finish item pads in the byte buffer one byte per cycle (pausing while a
// first block compresses), compressing one or two blocks, then emits eight
// digest words, one per cycle when m_axis is ready. With p bytes in the
// partial block the length spills into a second block when p >= 56. The
// digest register holds while the receiver stalls; no new item is taken
// until all eight words are delivered.
// After finish, chaining value and byte counter return to initial state.
// Reset (aresetn low, synchronous) loads the initial value and clears the
// counter and all handshake state.
`default_nettype none
module sm3_hash_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word, word_index, zero fill
    output logic             m_axis_tlast    // last_word
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_COMP = 5'b00010,
        ST_PAD  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [511:0] buf_reg;
    logic [63:0]  cnt_reg, bits_reg;
    logic [5:0]   pos_reg;
    logic [2:0]   widx_reg;
    logic         padding_reg, go_reg, init_reg;
    logic         tail_reg;
    logic         busy;
    logic [255:0] cv;
    logic [7:0]   pad_byte;

    sm3_round u_round (
        .aclk(aclk), .aresetn(aresetn), .start(go_reg), .block(buf_reg),
        .cv_init(init_reg), .busy(busy), .cv(cv)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {5'd0, widx_reg, cv[255 - 32*widx_reg -: 32]};
    assign m_axis_tlast  = (widx_reg == 3'd7);

    // tail_reg: the length field goes into the current block
    always_comb begin
        if (tail_reg && pos_reg >= 6'd56) begin
            pad_byte = bits_reg[63 - 8*pos_reg[2:0] -: 8];
        end else begin
            pad_byte = padding_reg ? 8'd0 : sm3_pkg::PAD_BYTE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            widx_reg    <= '0;
            padding_reg <= 1'b0;
            tail_reg    <= 1'b0;
            go_reg      <= 1'b0;
            init_reg    <= 1'b0;
        end else begin
            go_reg   <= 1'b0;
            init_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (!s_axis_tuser) begin
                            buf_reg[511 - 8*pos_reg -: 8] <= s_axis_tdata;
                            cnt_reg <= cnt_reg + 64'd1;
                            pos_reg <= pos_reg + 6'd1;
                            if (pos_reg == 6'd63) begin
                                go_reg    <= 1'b1;
                                state_reg <= ST_COMP;
                            end
                        end else begin
                            bits_reg    <= {cnt_reg[60:0], 3'b000};
                            padding_reg <= 1'b0;
                            tail_reg    <= (pos_reg < 6'd56);
                            state_reg   <= ST_PAD;
                        end
                    end
                end
                ST_COMP: begin
                    if (!go_reg && !busy) state_reg <= padding_reg ? ST_PAD : ST_IDLE;
                end
                ST_PAD: begin
                    buf_reg[511 - 8*pos_reg -: 8] <= pad_byte;
                    padding_reg <= 1'b1;
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63) begin
                        go_reg    <= 1'b1;
                        state_reg <= tail_reg ? ST_WAIT : ST_COMP;
                        tail_reg  <= 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (!go_reg && !busy) begin
                        widx_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            init_reg    <= 1'b1;
                            cnt_reg     <= '0;
                            pos_reg     <= '0;
                            padding_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
